// File: rtl/rlfd_pkg.sv
// Package with the shared constants and types of the run-length frame decoder.
package rlfd_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int MAX_ROWS  = 4096;

    localparam int COL_W  = 13;
    localparam int ROW_W  = 13;
    localparam int LIT_W  = 7;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [COL_W-1:0]  FRAME_WIDTH_RESET = 13'd32;
    localparam logic [ADDR_W-1:0] REG_FRAME_WIDTH   = 3'd0;

    localparam logic [7:0] HEADER_MAX_LITERAL = 8'h7F;
    localparam logic [7:0] HEADER_ZERO        = 8'h00;
    localparam logic [8:0] RUN_BASE           = 9'd256;

    localparam logic RESULT_RUN    = 1'b0;
    localparam logic RESULT_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_TRUNCATED = 2'd2
    } rlfd_err_t;

    typedef struct packed {
        logic        result_kind;
        logic        run_transparent;
        logic [7:0]  palette_index;
        logic [7:0]  run_length;
        logic [11:0] start_column;
        logic [11:0] row_index;
        logic        row_done;
        logic        frame_ok;
        logic [1:0]  error_code;
        logic        zero_warning;
        logic [12:0] row_count;
        logic        last_result;
    } rlfd_result_t;

    typedef struct packed {
        logic run_vld;
        logic stat_vld;
    } rlfd_push_t;

endpackage

// File: rtl/rlfd_if.sv
// Stream interfaces for compressed input bytes and decoded result transactions.
interface rlfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rlfd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        run_transparent;
    logic [7:0]  palette_index;
    logic [7:0]  run_length;
    logic [11:0] start_column;
    logic [11:0] row_index;
    logic        row_done;
    logic        frame_ok;
    logic [1:0]  error_code;
    logic        zero_warning;
    logic [12:0] row_count;
    logic        last_result;

    modport source (
        output valid, input ready,
        output result_kind, output run_transparent, output palette_index,
        output run_length, output start_column, output row_index, output row_done,
        output frame_ok, output error_code, output zero_warning, output row_count,
        output last_result
    );
    modport sink (
        input valid, output ready,
        input result_kind, input run_transparent, input palette_index,
        input run_length, input start_column, input row_index, input row_done,
        input frame_ok, input error_code, input zero_warning, input row_count,
        input last_result
    );
endinterface

// File: rtl/cel_run_length_frame_decoder_top.sv
// Top level of the run-length frame decoder.
// The decoder takes one compressed byte per cycle while the queue has room,
// updating the frame state in the same cycle and writing its run descriptor
// and, on the last byte, the end-of-frame status into a four-entry result
// queue. A last byte that also carries a run produces two results, and the
// queue drains one transaction per cycle while the output is ready.
// Input is accepted while the queue holds at most two results.
// The frame width register sits at byte address 0 and resets to 32.
module cel_run_length_frame_decoder_top
    import rlfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    rlfd_in_if.sink           in_ch,
    rlfd_out_if.source        out_ch
);

    logic [COL_W-1:0] frame_width;
    logic             take;
    logic             can_take;
    rlfd_push_t       push;
    rlfd_result_t     run_res;
    rlfd_result_t     stat_res;

    assign in_ch.ready = can_take;
    assign take        = in_ch.valid && can_take;

    rlfd_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .frame_width (frame_width)
    );

    rlfd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_width (frame_width),
        .take        (take),
        .data_byte   (in_ch.data_byte),
        .last_byte   (in_ch.last_byte),
        .push        (push),
        .run_res     (run_res),
        .stat_res    (stat_res)
    );

    rlfd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .run_res  (run_res),
        .stat_res (stat_res),
        .can_take (can_take),
        .out_ch   (out_ch)
    );

endmodule

// File: rtl/rlfd_cfg.sv
// APB-style configuration register block holding the frame width.
module rlfd_cfg
    import rlfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [COL_W-1:0]  frame_width
);

    logic [COL_W-1:0] frame_width_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == REG_FRAME_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RESET;
        end
        else if (wr_en)
        begin
            frame_width_reg <= pwdata[COL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_FRAME_WIDTH)
        begin
            prdata = {{(DATA_W-COL_W){1'b0}}, frame_width_reg};
        end
    end

    assign frame_width = frame_width_reg;

endmodule

// File: rtl/rlfd_decode.sv
// Frame state registers and the single-pass decode of one compressed byte.
module rlfd_decode
    import rlfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [COL_W-1:0] frame_width,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output rlfd_push_t       push,
    output rlfd_result_t     run_res,
    output rlfd_result_t     stat_res
);

    logic [LIT_W-1:0] literal_left_reg, literal_left_next;
    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] rows_reg, rows_next;
    rlfd_err_t        err_reg, err_next;
    logic             zero_reg, zero_next;

    logic [COL_W-1:0] width_act;
    logic             has_run;
    logic             transparent;
    logic [7:0]       run_len;
    logic [8:0]       run_len_wide;
    logic [COL_W:0]   run_end;
    logic             overflow;
    logic             done;

    always_comb
    begin
        if (frame_width == '0)
        begin
            width_act = COL_W'(1);
        end
        else if (frame_width > COL_W'(MAX_WIDTH))
        begin
            width_act = COL_W'(MAX_WIDTH);
        end
        else
        begin
            width_act = frame_width;
        end
    end

    always_comb
    begin
        literal_left_next = literal_left_reg;
        column_next       = column_reg;
        rows_next         = rows_reg;
        err_next          = err_reg;
        zero_next         = zero_reg;
        has_run           = 1'b0;
        transparent       = 1'b0;
        run_len_wide      = RUN_BASE - {1'b0, data_byte};
        run_len           = 8'd1;
        run_end           = '0;
        overflow          = 1'b0;
        done              = 1'b0;

        if (err_reg == ERR_NONE)
        begin
            priority if (literal_left_reg != '0)
            begin
                literal_left_next = literal_left_reg - LIT_W'(1);
                has_run           = 1'b1;
            end
            else if (data_byte > HEADER_MAX_LITERAL)
            begin
                has_run     = 1'b1;
                transparent = 1'b1;
                run_len     = run_len_wide[7:0];
            end
            else if (data_byte == HEADER_ZERO)
            begin
                zero_next = 1'b1;
            end
            else
            begin
                literal_left_next = data_byte[LIT_W-1:0];
            end
        end

        if (has_run)
        begin
            run_end  = {1'b0, column_reg} + {{(COL_W-7){1'b0}}, run_len};
            overflow = run_end > {1'b0, width_act};
            done     = (run_end == {1'b0, width_act}) && (literal_left_next == '0);
            if (overflow)
            begin
                err_next = ERR_OVERFLOW;
            end
            else if (done)
            begin
                column_next = '0;
                if (rows_reg < ROW_W'(MAX_ROWS))
                begin
                    rows_next = rows_reg + ROW_W'(1);
                end
            end
            else
            begin
                column_next = run_end[COL_W-1:0];
            end
        end

        if (last_byte && (literal_left_next != '0) && (err_next == ERR_NONE))
        begin
            err_next = ERR_TRUNCATED;
        end
    end

    always_comb
    begin
        push.run_vld  = take && has_run && !overflow;
        push.stat_vld = take && last_byte;

        run_res                 = '0;
        run_res.result_kind     = RESULT_RUN;
        run_res.run_transparent = transparent;
        run_res.palette_index   = transparent ? 8'd0 : data_byte;
        run_res.run_length      = run_len;
        run_res.start_column    = column_reg[11:0];
        run_res.row_index       = rows_reg[11:0];
        run_res.row_done        = done;
        run_res.last_result     = !last_byte;

        stat_res              = '0;
        stat_res.result_kind  = RESULT_STATUS;
        stat_res.frame_ok     = (err_next == ERR_NONE) && (column_next == '0);
        stat_res.error_code   = err_next;
        stat_res.zero_warning = zero_next;
        stat_res.row_count    = rows_next;
        stat_res.last_result  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            literal_left_reg <= '0;
            column_reg       <= '0;
            rows_reg         <= '0;
            err_reg          <= ERR_NONE;
            zero_reg         <= 1'b0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                literal_left_reg <= '0;
                column_reg       <= '0;
                rows_reg         <= '0;
                err_reg          <= ERR_NONE;
                zero_reg         <= 1'b0;
            end
            else
            begin
                literal_left_reg <= literal_left_next;
                column_reg       <= column_next;
                rows_reg         <= rows_next;
                err_reg          <= err_next;
                zero_reg         <= zero_next;
            end
        end
    end

endmodule

// File: rtl/rlfd_outq.sv
// Four-entry result queue that takes up to two results per cycle and issues one.
module rlfd_outq
    import rlfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rlfd_push_t   push,
    input  rlfd_result_t run_res,
    input  rlfd_result_t stat_res,
    output logic         can_take,
    rlfd_out_if.source   out_ch
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    rlfd_result_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [1:0]       n_push;
    logic             pop;
    rlfd_result_t     first_res;
    rlfd_result_t     head;

    assign n_push    = {1'b0, push.run_vld} + {1'b0, push.stat_vld};
    assign first_res = push.run_vld ? run_res : stat_res;
    assign pop       = out_ch.valid && out_ch.ready;
    assign can_take  = count_reg < (PTR_W+1)'(DEPTH - 1);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= first_res;
        end
        if (n_push == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= stat_res;
        end
    end

    assign head = mem_reg[rd_ptr_reg];

    assign out_ch.valid           = count_reg != '0;
    assign out_ch.result_kind     = head.result_kind;
    assign out_ch.run_transparent = head.run_transparent;
    assign out_ch.palette_index   = head.palette_index;
    assign out_ch.run_length      = head.run_length;
    assign out_ch.start_column    = head.start_column;
    assign out_ch.row_index       = head.row_index;
    assign out_ch.row_done        = head.row_done;
    assign out_ch.frame_ok        = head.frame_ok;
    assign out_ch.error_code      = head.error_code;
    assign out_ch.zero_warning    = head.zero_warning;
    assign out_ch.row_count       = head.row_count;
    assign out_ch.last_result     = head.last_result;

endmodule
